// ===== sv/mstt_pkg.sv =====
// Timer table package: sizes, opcodes, result kinds and the slot record.
// Shared by the channel interfaces, the RAM users and the top level.
// No dependencies.
package mstt_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int TIME_BITS   = 48;
   localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
   localparam int COUNT_BITS  = $clog2(SLOT_COUNT + 1);
   localparam int OP_BITS     = 2;
   localparam int KIND_BITS   = 2;
   localparam int ID_BITS     = 4;
   localparam int ELAPSE_BITS = 16;
   localparam int DUR_BITS    = 32;
   localparam int REP_BITS    = 32;

   // request opcodes
   localparam logic [OP_BITS-1:0] OP_TICK     = 2'd0;
   localparam logic [OP_BITS-1:0] OP_NOW      = 2'd1;
   localparam logic [OP_BITS-1:0] OP_DELAY    = 2'd2;
   localparam logic [OP_BITS-1:0] OP_PERIODIC = 2'd3;

   // response kinds
   localparam logic [KIND_BITS-1:0] KIND_ACCEPT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_REJECT = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_FIRED  = 2'd2;

   // one slot entry as kept in the slot RAM
   typedef struct packed {
      logic [TIME_BITS-1:0] next_time;
      logic [DUR_BITS-1:0]  interval;
      logic [REP_BITS-1:0]  remaining;
      logic                 periodic;
   } slot_rec_type;

   localparam int SLOT_REC_BITS = $bits(slot_rec_type);

   // response held back until it is known whether it is the last one
   typedef struct packed {
      logic                 valid;
      logic                 closed;
      logic [KIND_BITS-1:0] kind;
      logic [ID_BITS-1:0]   id;
   } pend_type;

   // low bits of a slot number as reported on the response channel
   function automatic logic [ID_BITS-1:0] to_id(input logic [SLOT_BITS-1:0] slot);
      logic [63:0] wide;
      wide = 64'(slot);
      return wide[ID_BITS-1:0];
   endfunction

endpackage

// ===== sv/mstt_req_if.sv =====
// Request channel of the timer table: valid/ready plus request payload.
// Depends on mstt_pkg for field widths.
interface mstt_req_if;
   logic                              valid;
   logic                              ready;
   logic [mstt_pkg::OP_BITS-1:0]      opcode;
   logic [mstt_pkg::ELAPSE_BITS-1:0]  elapsed_ms;
   logic [mstt_pkg::DUR_BITS-1:0]     duration_ms;
   logic [mstt_pkg::REP_BITS-1:0]     repeat_count;

   modport source (output valid, opcode, elapsed_ms, duration_ms, repeat_count,
                   input ready);
   modport sink   (input valid, opcode, elapsed_ms, duration_ms, repeat_count,
                   output ready);
endinterface

// ===== sv/mstt_rsp_if.sv =====
// Response channel of the timer table: valid/ready plus response payload.
// Depends on mstt_pkg for field widths.
interface mstt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mstt_pkg::KIND_BITS-1:0]  kind;
   logic [mstt_pkg::ID_BITS-1:0]    slot_id;
   logic                            last;

   modport source (output valid, kind, slot_id, last, input ready);
   modport sink   (input valid, kind, slot_id, last, output ready);
endinterface

// ===== sv/mstt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while no read is issued. No dependencies.
module mstt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write, then registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/multi_slot_software_timer_table.sv =====
// Timer table top level: one-shot and periodic slots scanned on each tick.
// Depends on mstt_pkg, mstt_req_if, mstt_rsp_if and mstt_ram.
//
//   channel    | role   | payload                                        | handshake
//   req_chan   | sink   | opcode, elapsed_ms, duration_ms, repeat_count  | valid & ready
//   rsp_chan   | source | kind, slot_id, last                            | valid & ready
//
// A schedule request is taken only while idle with no response pending; its response
// passes the pending register, then the response register. A tick reads the fire-order
// RAM, then the slot RAM, one entry per cycle unless stalled, via a two-deep pipeline.
// A fired response is held one entry back until it is known to be the last one.
// Reset clears the live flags, the live count and the clock; no RAM clearing pass.
// A stalled response channel freezes the scan only when a second slot fires.
module multi_slot_software_timer_table (
   input  logic       clock,
   input  logic       reset,
   mstt_req_if.sink   req_chan,
   mstt_rsp_if.source rsp_chan
);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type                          state_ff, state_in;
   logic [mstt_pkg::TIME_BITS-1:0]     cur_time_ff, cur_time_in;
   logic [mstt_pkg::SLOT_COUNT-1:0]    live_ff, live_in;
   logic [mstt_pkg::COUNT_BITS-1:0]    live_count_ff, live_count_in;
   logic [mstt_pkg::COUNT_BITS-1:0]    rd_idx_ff, rd_idx_in;
   logic [mstt_pkg::COUNT_BITS-1:0]    wr_idx_ff, wr_idx_in;
   logic                               ord_v_ff, ord_v_in;
   logic                               ev_v_ff, ev_v_in;
   logic [mstt_pkg::SLOT_BITS-1:0]     ev_id_ff, ev_id_in;
   mstt_pkg::pend_type                 pend_ff, pend_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mstt_pkg::KIND_BITS-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [mstt_pkg::ID_BITS-1:0]       rsp_id_ff, rsp_id_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                               slot_we, slot_re;
   logic [mstt_pkg::SLOT_BITS-1:0]     slot_waddr, slot_raddr;
   mstt_pkg::slot_rec_type             slot_wdata, slot_rdata;
   logic [mstt_pkg::SLOT_REC_BITS-1:0] slot_rdata_raw;

   logic                               ord_we, ord_re;
   logic [mstt_pkg::SLOT_BITS-1:0]     ord_waddr, ord_raddr;
   logic [mstt_pkg::SLOT_BITS-1:0]     ord_wdata, ord_rdata;

   logic                               req_ready, rsp_free;
   logic                               free_found;
   logic [mstt_pkg::SLOT_BITS-1:0]     free_id;
   logic                               due, expire, stall;
   logic [mstt_pkg::TIME_BITS-1:0]     sched_delay;

   // slot records
   mstt_ram #(
      .WIDTH (mstt_pkg::SLOT_REC_BITS),
      .DEPTH (mstt_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (slot_re),
      .raddr (slot_raddr),
      .rdata (slot_rdata_raw)
   );

   assign slot_rdata = mstt_pkg::slot_rec_type'(slot_rdata_raw);

   // slot ids in insertion order
   mstt_ram #(
      .WIDTH (mstt_pkg::SLOT_BITS),
      .DEPTH (mstt_pkg::SLOT_COUNT)
   ) u_order_ram (
      .clock (clock),
      .we    (ord_we),
      .waddr (ord_waddr),
      .wdata (ord_wdata),
      .re    (ord_re),
      .raddr (ord_raddr),
      .rdata (ord_rdata)
   );

   // find the lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_id    = '0;
      for (int i = mstt_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_found = 1'b1;
            free_id    = mstt_pkg::SLOT_BITS'(i);
         end
      end
   end

   // evaluate the slot at the end of the read pipeline
   assign due    = (cur_time_ff >= slot_rdata.next_time);
   assign expire = !slot_rdata.periodic || (slot_rdata.remaining == mstt_pkg::REP_BITS'(1));

   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready   = (state_ff == ST_IDLE) && !pend_ff.valid;
   assign stall       = ev_v_ff && due && pend_ff.valid && !rsp_free;
   assign sched_delay = (req_chan.opcode == mstt_pkg::OP_NOW) ? '0 :
                        mstt_pkg::TIME_BITS'(req_chan.duration_ms);

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      cur_time_in   = cur_time_ff;
      live_in       = live_ff;
      live_count_in = live_count_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      ord_v_in      = ord_v_ff;
      ev_v_in       = ev_v_ff;
      ev_id_in      = ev_id_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;

      slot_we    = 1'b0;
      slot_waddr = '0;
      slot_wdata = '0;
      slot_re    = 1'b0;
      slot_raddr = '0;
      ord_we     = 1'b0;
      ord_waddr  = '0;
      ord_wdata  = '0;
      ord_re     = 1'b0;
      ord_raddr  = '0;

      // drop a response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // release a closed pending response as the last one
      if (pend_ff.valid && pend_ff.closed && rsp_free) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = pend_ff.kind;
         rsp_id_in      = pend_ff.id;
         rsp_last_in    = 1'b1;
         pend_in.valid  = 1'b0;
         pend_in.closed = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid && req_ready) begin
               if (req_chan.opcode == mstt_pkg::OP_TICK) begin
                  // advance the clock and start the scan
                  cur_time_in = cur_time_ff + mstt_pkg::TIME_BITS'(req_chan.elapsed_ms);
                  rd_idx_in   = '0;
                  wr_idx_in   = '0;
                  ord_v_in    = 1'b0;
                  ev_v_in     = 1'b0;
                  state_in    = ST_SCAN;
               end else if (!free_found) begin
                  pend_in = '{valid: 1'b1, closed: 1'b1, kind: mstt_pkg::KIND_REJECT,
                              id: '0};
               end else begin
                  // claim the slot and append it to the firing order
                  live_in[free_id]     = 1'b1;
                  slot_we              = 1'b1;
                  slot_waddr           = free_id;
                  slot_wdata.next_time = cur_time_ff + sched_delay;
                  slot_wdata.interval  = (req_chan.opcode == mstt_pkg::OP_NOW) ? '0 :
                                         req_chan.duration_ms;
                  slot_wdata.remaining = (req_chan.opcode == mstt_pkg::OP_PERIODIC) ?
                                         req_chan.repeat_count : '0;
                  slot_wdata.periodic  = (req_chan.opcode == mstt_pkg::OP_PERIODIC);
                  ord_we               = 1'b1;
                  ord_waddr            = live_count_ff[mstt_pkg::SLOT_BITS-1:0];
                  ord_wdata            = free_id;
                  live_count_in        = live_count_ff + 1'b1;
                  pend_in = '{valid: 1'b1, closed: 1'b1, kind: mstt_pkg::KIND_ACCEPT,
                              id: mstt_pkg::to_id(free_id)};
               end
            end
         end

         ST_SCAN: begin
            if (!stall) begin
               // issue the fire-order read
               ord_re    = (rd_idx_ff < live_count_ff);
               ord_raddr = rd_idx_ff[mstt_pkg::SLOT_BITS-1:0];
               ord_v_in  = ord_re;
               if (ord_re) begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end

               // issue the slot read
               slot_re    = ord_v_ff;
               slot_raddr = ord_rdata;
               ev_v_in    = ord_v_ff;
               ev_id_in   = ord_rdata;

               // fire, reschedule or free the evaluated slot
               if (ev_v_ff) begin
                  if (due) begin
                     if (pend_ff.valid) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = pend_ff.kind;
                        rsp_id_in    = pend_ff.id;
                        rsp_last_in  = 1'b0;
                     end
                     pend_in = '{valid: 1'b1, closed: 1'b0, kind: mstt_pkg::KIND_FIRED,
                                 id: mstt_pkg::to_id(ev_id_ff)};
                  end
                  if (due && expire) begin
                     live_in[ev_id_ff] = 1'b0;
                  end else begin
                     ord_we    = 1'b1;
                     ord_waddr = wr_idx_ff[mstt_pkg::SLOT_BITS-1:0];
                     ord_wdata = ev_id_ff;
                     wr_idx_in = wr_idx_ff + 1'b1;
                  end
                  if (due && !expire) begin
                     slot_we              = 1'b1;
                     slot_waddr           = ev_id_ff;
                     slot_wdata.next_time = cur_time_ff +
                                            mstt_pkg::TIME_BITS'(slot_rdata.interval);
                     slot_wdata.interval  = slot_rdata.interval;
                     slot_wdata.remaining = (slot_rdata.remaining != '0) ?
                                            slot_rdata.remaining - 1'b1 : '0;
                     slot_wdata.periodic  = slot_rdata.periodic;
                  end
               end

               // close the scan once the pipeline is empty
               if (!ord_v_ff && !ev_v_ff && (rd_idx_ff == live_count_ff)) begin
                  live_count_in = wr_idx_ff;
                  state_in      = ST_IDLE;
                  if (pend_ff.valid) begin
                     pend_in.closed = 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      ev_id_ff    <= ev_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_time_ff   <= '0;
         live_ff       <= '0;
         live_count_ff <= '0;
         rd_idx_ff     <= '0;
         wr_idx_ff     <= '0;
         ord_v_ff      <= 1'b0;
         ev_v_ff       <= 1'b0;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_time_ff   <= cur_time_in;
         live_ff       <= live_in;
         live_count_ff <= live_count_in;
         rd_idx_ff     <= rd_idx_in;
         wr_idx_ff     <= wr_idx_in;
         ord_v_ff      <= ord_v_in;
         ev_v_ff       <= ev_v_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind  = rsp_kind_ff;
   assign rsp_chan.slot_id = rsp_id_ff;
   assign rsp_chan.last  = rsp_last_ff;

   // live count tracks the live flags between scans
   a_live_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         (live_count_ff == mstt_pkg::COUNT_BITS'($countones(live_ff))))
      else $error("live count does not match live flags");

   // compaction never overtakes the read index
   a_compact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (wr_idx_ff <= rd_idx_ff))
      else $error("fire-order write index ahead of read index");

   // a schedule request leaves a closed pending response
   a_sched_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.opcode != mstt_pkg::OP_TICK)) |=>
         (pend_ff.valid && pend_ff.closed))
      else $error("schedule request left no response");

endmodule

// ===== test/timer_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the timer table: watches the request and response channels,
// predicts the slot reports of every accepted request and compares them in order.
// Depends on mstt_pkg, mstt_req_if and mstt_rsp_if.
module timer_table_checker (
   input  logic clock,
   input  logic reset,
   mstt_req_if  req_mon,
   mstt_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   typedef struct packed {
      logic [mstt_pkg::KIND_BITS-1:0] kind;
      logic [mstt_pkg::ID_BITS-1:0]   slot_id;
      logic                           last;
   } slot_report_type;

   // reports still owed by the block, oldest first
   slot_report_type awaited_reports[$];
   slot_report_type seen_report;

   // shadow copy of the timer table
   logic [mstt_pkg::TIME_BITS-1:0] now_ms;
   logic [mstt_pkg::TIME_BITS-1:0] due_ms      [mstt_pkg::SLOT_COUNT];
   logic [mstt_pkg::DUR_BITS-1:0]  period_ms   [mstt_pkg::SLOT_COUNT];
   logic [mstt_pkg::REP_BITS-1:0]  shots_left  [mstt_pkg::SLOT_COUNT];
   logic                           is_periodic [mstt_pkg::SLOT_COUNT];
   logic                           in_use      [mstt_pkg::SLOT_COUNT];
   logic [mstt_pkg::SLOT_BITS-1:0] fire_seq    [mstt_pkg::SLOT_COUNT];
   int                             used_count;

   // Advance the clock, report every due slot in firing order, then retire spent slots.
   task automatic predict_tick(input logic [mstt_pkg::ELAPSE_BITS-1:0] elapsed);
      logic                           retire [mstt_pkg::SLOT_COUNT];
      logic [mstt_pkg::SLOT_BITS-1:0] s;
      int                             fired;
      int                             keep;
      fired = 0;
      keep  = 0;
      now_ms = now_ms + mstt_pkg::TIME_BITS'(elapsed);
      for (int i = 0; i < used_count; i++) begin
         s = fire_seq[i];
         retire[i] = 1'b0;
         if (now_ms >= due_ms[s]) begin
            awaited_reports.push_back(slot_report_type'{mstt_pkg::KIND_FIRED,
                                      mstt_pkg::ID_BITS'(s), 1'b0});
            fired++;
            if (!is_periodic[s]) begin
               retire[i] = 1'b1;
            end else begin
               // a zero count never runs out
               if (shots_left[s] != '0) begin
                  shots_left[s] = shots_left[s] - 1'b1;
                  if (shots_left[s] == '0) retire[i] = 1'b1;
               end
               if (!retire[i]) due_ms[s] = now_ms + mstt_pkg::TIME_BITS'(period_ms[s]);
            end
         end
      end
      // compact the firing order, keeping survivors in their relative order
      for (int i = 0; i < used_count; i++) begin
         s = fire_seq[i];
         if (retire[i]) begin
            in_use[s] = 1'b0;
         end else begin
            fire_seq[keep] = s;
            keep++;
         end
      end
      used_count = keep;
      if (fired > 0) awaited_reports[awaited_reports.size() - 1].last = 1'b1;
   endtask

   // Claim the lowest free slot and append it to the firing order, or reject when full.
   task automatic predict_schedule(input logic [mstt_pkg::OP_BITS-1:0]  op,
                                   input logic [mstt_pkg::DUR_BITS-1:0] dur,
                                   input logic [mstt_pkg::REP_BITS-1:0] rep);
      int                             free_slot;
      logic [mstt_pkg::TIME_BITS-1:0] delay_ms;
      free_slot = -1;
      for (int s = mstt_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
         if (!in_use[s]) free_slot = s;
      end
      if (free_slot < 0 || used_count >= mstt_pkg::SLOT_COUNT) begin
         awaited_reports.push_back(slot_report_type'{mstt_pkg::KIND_REJECT,
                                   mstt_pkg::ID_BITS'(0), 1'b1});
      end else begin
         delay_ms = (op == mstt_pkg::OP_NOW) ? '0 : mstt_pkg::TIME_BITS'(dur);
         in_use[free_slot]      = 1'b1;
         is_periodic[free_slot] = (op == mstt_pkg::OP_PERIODIC);
         period_ms[free_slot]   = (op == mstt_pkg::OP_NOW) ? '0 : dur;
         shots_left[free_slot]  = (op == mstt_pkg::OP_PERIODIC) ? rep : '0;
         due_ms[free_slot]      = now_ms + delay_ms;
         fire_seq[used_count]   = mstt_pkg::SLOT_BITS'(free_slot);
         used_count++;
         awaited_reports.push_back(slot_report_type'{mstt_pkg::KIND_ACCEPT,
                                   mstt_pkg::ID_BITS'(free_slot), 1'b1});
      end
   endtask

   // Count a mismatch, printing only the first few.
   task automatic flag_mismatch(input string what, input slot_report_type want,
                                input slot_report_type got);
      if (mismatch_count < 10) begin
         $display("%0t: %s: expected kind=%0d slot=%0d last=%0d, got kind=%0d slot=%0d last=%0d",
                  $time, what, want.kind, want.slot_id, want.last,
                  got.kind, got.slot_id, got.last);
      end
      mismatch_count++;
   endtask

   // Predict on each accepted request, then compare each accepted response.
   always @(posedge clock) begin
      if (reset) begin
         now_ms     = '0;
         used_count = 0;
         for (int s = 0; s < mstt_pkg::SLOT_COUNT; s++) in_use[s] = 1'b0;
         awaited_reports.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.opcode == mstt_pkg::OP_TICK) begin
               predict_tick(req_mon.elapsed_ms);
            end else begin
               predict_schedule(req_mon.opcode, req_mon.duration_ms, req_mon.repeat_count);
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen_report = '{rsp_mon.kind, rsp_mon.slot_id, rsp_mon.last};
            if (awaited_reports.size() == 0) begin
               flag_mismatch("unexpected response", '0, seen_report);
            end else begin
               if (seen_report.kind !== awaited_reports[0].kind ||
                   seen_report.slot_id !== awaited_reports[0].slot_id ||
                   seen_report.last !== awaited_reports[0].last) begin
                  flag_mismatch("response mismatch", awaited_reports[0], seen_report);
               end
               void'(awaited_reports.pop_front());
            end
         end
      end
      pending_count = awaited_reports.size();
   end

endmodule

// ===== test/multi_slot_software_timer_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the timer table: clock, reset, request stimulus and response stalls.
// Depends on mstt_pkg, the channel interfaces, the block and timer_table_checker.
module multi_slot_software_timer_table_tb;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 64;
   localparam int RANDOM_REQUESTS = 200;
   localparam int LONG_HOLD       = 600;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PATTERN} ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic long_hold_go = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count;
   int   pending_count;

   mstt_req_if req_bus();
   mstt_rsp_if rsp_bus();

   multi_slot_software_timer_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   timer_table_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one request from the falling edge and hold it until accepted.
   task automatic send_request(input logic [mstt_pkg::OP_BITS-1:0]     op,
                               input logic [mstt_pkg::ELAPSE_BITS-1:0] elapsed,
                               input logic [mstt_pkg::DUR_BITS-1:0]    dur,
                               input logic [mstt_pkg::REP_BITS-1:0]    rep);
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.elapsed_ms   <= elapsed;
      req_bus.duration_ms  <= dur;
      req_bus.repeat_count <= rep;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drop valid for a number of cycles.
   task automatic idle_for(input int cycles);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drop valid and hold until every predicted report has come back.
   task automatic wait_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Response side: stretches of differing stall patterns, plus one long hold-off.
   initial begin : rsp_ready_driver
      ready_mode_type mode;
      int             span;
      logic [7:0]     ready_pattern;
      bit             hold_done;
      rsp_bus.ready = 1'b0;
      ready_pattern = 8'b1011_0010;
      hold_done     = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_go && !hold_done) begin
            // back up the response path so the block stalls its requests
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            mode = ready_mode_type'($urandom_range(0, 3));
            span = $urandom_range(8, 80);
            repeat (span) begin
               case (mode)
                  READY_ALWAYS: rsp_bus.ready <= 1'b1;
                  READY_HALF:   rsp_bus.ready <= 1'($urandom_range(0, 1));
                  READY_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                  default: begin
                     rsp_bus.ready <= ready_pattern[0];
                     ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
                  end
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // Request side: directed sequence, then random bursts.
   initial begin : req_stimulus
      logic [mstt_pkg::OP_BITS-1:0]     op;
      logic [mstt_pkg::ELAPSE_BITS-1:0] elapsed;
      logic [mstt_pkg::DUR_BITS-1:0]    dur;
      logic [mstt_pkg::REP_BITS-1:0]    rep;
      int                               sent;
      int                               burst;
      int                               roll;
      int                               pick;

      req_bus.valid        = 1'b0;
      req_bus.opcode       = mstt_pkg::OP_TICK;
      req_bus.elapsed_ms   = '0;
      req_bus.duration_ms  = '0;
      req_bus.repeat_count = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tick on an empty table: no report
      send_request(mstt_pkg::OP_TICK, '0, $urandom, $urandom);
      // one of each schedule kind, unused fields carry noise
      send_request(mstt_pkg::OP_NOW, 16'($urandom), $urandom, $urandom);
      send_request(mstt_pkg::OP_DELAY, 16'($urandom), '0, $urandom);
      send_request(mstt_pkg::OP_DELAY, 16'($urandom), 32'd5, $urandom);
      send_request(mstt_pkg::OP_PERIODIC, 16'($urandom), 32'd3, 32'd2);
      // fire the due-now slots, then the delayed and periodic ones
      send_request(mstt_pkg::OP_TICK, '0, $urandom, $urandom);
      send_request(mstt_pkg::OP_TICK, 16'd5, $urandom, $urandom);
      // largest step; periodic slot runs out of repeats
      send_request(mstt_pkg::OP_TICK, 16'hFFFF, $urandom, $urandom);
      // zero-interval forever slot, and slots that never come due
      send_request(mstt_pkg::OP_PERIODIC, 16'($urandom), '0, '0);
      send_request(mstt_pkg::OP_DELAY, 16'($urandom), 32'hFFFF_FFFF, $urandom);
      send_request(mstt_pkg::OP_PERIODIC, 16'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(mstt_pkg::OP_PERIODIC, 16'($urandom), 32'd1, 32'd1);
      // fill the table, then one request past full
      repeat (mstt_pkg::SLOT_COUNT - 4) begin
         send_request(mstt_pkg::OP_NOW, 16'($urandom), $urandom, $urandom);
      end
      send_request(mstt_pkg::OP_DELAY, 16'($urandom), $urandom, $urandom);
      // full table tick: many slots fire at once
      send_request(mstt_pkg::OP_TICK, 16'd1, $urandom, $urandom);
      wait_until_drained();

      // random bursts; the long response hold-off starts during this part
      long_hold_go = 1'b1;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < RANDOM_REQUESTS; k++) begin
            roll    = $urandom_range(0, 99);
            elapsed = 16'($urandom);
            dur     = $urandom;
            rep     = $urandom;
            if (roll < 35) begin
               op   = mstt_pkg::OP_TICK;
               pick = $urandom_range(0, 9);
               if (pick == 0) elapsed = '0;
               else if (pick > 1) elapsed = 16'($urandom_range(1, 20));
            end else if (roll < 50) begin
               op = mstt_pkg::OP_NOW;
            end else if (roll < 70) begin
               op  = mstt_pkg::OP_DELAY;
               dur = ($urandom_range(0, 9) == 0) ? '0 : 32'($urandom_range(1, 40));
            end else begin
               op  = mstt_pkg::OP_PERIODIC;
               dur = 32'($urandom_range(0, 15));
               rep = 32'($urandom_range(1, 6));
            end
            send_request(op, elapsed, dur, rep);
            sent++;
            // pause the sender once until the block has caught up
            if (sent == RANDOM_REQUESTS / 2) wait_until_drained();
         end
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
      end

      // let the last scan settle before the verdict
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
